// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent check shorthands shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define VBS_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: label");

// Next-cycle implication, checked out of reset.
`define VBS_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: label");

`else

`define VBS_ASSERT_IMP(label, clk, rst_n, a, b)
`define VBS_ASSERT_NXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== rtl/vbs_pkg.sv =====
// ----------------------------------------------------------------------------
// vbs_pkg
// Types and constants of the vibration burst sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package vbs_pkg;

  typedef enum logic [1:0] {
    OP_PAT_TICK = 2'd0,
    OP_PWM_TICK = 2'd1,
    OP_START    = 2'd2,
    OP_STOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PAT_ALARM    = 2'd0,
    PAT_INCOMING = 2'd1,
    PAT_TEST     = 2'd2,
    PAT_KEEP     = 2'd3
  } pat_t;

  localparam int unsigned DurW   = 16;
  localparam int unsigned CountW = 4;
  localparam int unsigned IdxW   = 3;

  localparam logic [IdxW-1:0] REG_ALARM_ON     = 3'd0;
  localparam logic [IdxW-1:0] REG_ALARM_OFF    = 3'd1;
  localparam logic [IdxW-1:0] REG_INCOMING_ON  = 3'd2;
  localparam logic [IdxW-1:0] REG_INCOMING_OFF = 3'd3;
  localparam logic [IdxW-1:0] REG_TEST_ON      = 3'd4;
  localparam logic [IdxW-1:0] REG_TEST_OFF     = 3'd5;

  localparam logic [CountW-1:0] BURSTS_ALARM    = 4'd10;
  localparam logic [CountW-1:0] BURSTS_INCOMING = 4'd7;
  localparam logic [CountW-1:0] BURSTS_TEST     = 4'd2;

  localparam logic [1:0] PHASE_LAST = 2'd2;

  typedef struct packed {
    op_t        op;
    pat_t       pattern;
    logic       display_busy;
  } in_word_t;

  typedef struct packed {
    logic              motor_on;
    logic              active;
    logic              pwm_running;
    logic [CountW-1:0] bursts_left;
  } out_word_t;

  typedef struct packed {
    logic [DurW-1:0] alarm_on;
    logic [DurW-1:0] alarm_off;
    logic [DurW-1:0] incoming_on;
    logic [DurW-1:0] incoming_off;
    logic [DurW-1:0] test_on;
    logic [DurW-1:0] test_off;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/vbs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vbs_cfg_regs
// Duration register file written through the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_cfg_regs
  import vbs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_en,
  input  wire logic [IdxW-1:0] wr_index,
  input  wire logic [DurW-1:0] wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_ALARM_ON:     cfg_nxt.alarm_on     = wr_data;
        REG_ALARM_OFF:    cfg_nxt.alarm_off    = wr_data;
        REG_INCOMING_ON:  cfg_nxt.incoming_on  = wr_data;
        REG_INCOMING_OFF: cfg_nxt.incoming_off = wr_data;
        REG_TEST_ON:      cfg_nxt.test_on      = wr_data;
        REG_TEST_OFF:     cfg_nxt.test_off     = wr_data;
        default:          cfg_nxt = cfg_r; // drop writes past the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== rtl/vbs_core.sv =====
// ----------------------------------------------------------------------------
// vbs_core
// Sequencer state and its registered update for one event word.
// ----------------------------------------------------------------------------
`default_nettype none

module vbs_core
  import vbs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     step,
  input  wire in_word_t word,
  input  wire cfg_t     cfg,
  output out_word_t     result_nxt
);

  logic              enabled_r,  enabled_nxt;
  logic              pwm_on_r,   pwm_on_nxt;
  logic [1:0]        phase_r,    phase_nxt;
  logic              drive_r,    drive_nxt;
  logic [CountW-1:0] count_r,    count_nxt;
  logic [1:0]        kind_r,     kind_nxt;
  logic [DurW-1:0]   on_r,       on_nxt;
  logic [DurW-1:0]   off_r,      off_nxt;

  // Durations for a stored kind; kind 3 loads nothing.
  function automatic logic load_hit(input logic [1:0] k);
    load_hit = (k != PAT_KEEP);
  endfunction

  function automatic logic [2*DurW-1:0] durations(input logic [1:0] k, input cfg_t c);
    logic [2*DurW-1:0] d;
    case (k)
      PAT_ALARM:    d = {c.alarm_on, c.alarm_off};
      PAT_INCOMING: d = {c.incoming_on, c.incoming_off};
      PAT_TEST:     d = {c.test_on, c.test_off};
      default:      d = '0;
    endcase
    durations = d;
  endfunction

  logic [2*DurW-1:0] reload_dur;
  logic [2*DurW-1:0] start_dur;
  logic [1:0]        start_kind;
  logic [1:0]        phase_inc;

  always_comb begin
    reload_dur = durations(kind_r, cfg);
    start_kind = (word.pattern == PAT_ALARM) ? PAT_ALARM : PAT_INCOMING;
    start_dur  = durations(start_kind, cfg);
    phase_inc  = (phase_r >= PHASE_LAST) ? 2'd0 : phase_r + 2'd1;

    enabled_nxt = enabled_r;
    pwm_on_nxt  = pwm_on_r;
    phase_nxt   = phase_r;
    drive_nxt   = drive_r;
    count_nxt   = count_r;
    kind_nxt    = kind_r;
    on_nxt      = on_r;
    off_nxt     = off_r;

    case (word.op)
      OP_PAT_TICK: begin
        if (enabled_r) begin
          if (count_r != '0) begin
            if (on_r != '0) begin
              on_nxt = on_r - 1'b1;
              if (on_r == DurW'(1)) begin
                pwm_on_nxt = 1'b0;
                drive_nxt  = 1'b0;
              end
            end else if (off_r != '0 && off_r != DurW'(1)) begin
              off_nxt = off_r - 1'b1;
            end else begin
              // Off time expired or both durations empty: start next burst.
              if (off_r != '0) begin
                off_nxt = '0;
              end
              if (load_hit(kind_r)) begin
                on_nxt  = reload_dur[2*DurW-1:DurW];
                off_nxt = reload_dur[DurW-1:0];
              end
              pwm_on_nxt = 1'b1;
              count_nxt  = count_r - 1'b1;
            end
          end else begin
            drive_nxt   = 1'b0;
            pwm_on_nxt  = 1'b0;
            enabled_nxt = 1'b0;
          end
        end
      end
      OP_PWM_TICK: begin
        if (pwm_on_r) begin
          phase_nxt = phase_inc;
          drive_nxt = (phase_inc == 2'd0);
        end
      end
      OP_START: begin
        if (!word.display_busy) begin
          if (word.pattern != PAT_KEEP) begin
            kind_nxt = start_kind;
            on_nxt   = start_dur[2*DurW-1:DurW];
            off_nxt  = start_dur[DurW-1:0];
            case (word.pattern)
              PAT_ALARM:    count_nxt = BURSTS_ALARM;
              PAT_INCOMING: count_nxt = BURSTS_INCOMING;
              default:      count_nxt = BURSTS_TEST;
            endcase
          end
          enabled_nxt = 1'b1;
          phase_nxt   = 2'd0;
          drive_nxt   = 1'b1;
          pwm_on_nxt  = 1'b1;
        end
      end
      default: begin
        drive_nxt = 1'b0;
        if (enabled_r) begin
          pwm_on_nxt  = 1'b0;
          enabled_nxt = 1'b0;
        end
      end
    endcase

    result_nxt.motor_on    = drive_nxt;
    result_nxt.active      = enabled_nxt;
    result_nxt.pwm_running = pwm_on_nxt;
    result_nxt.bursts_left = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      pwm_on_r  <= 1'b0;
      phase_r   <= 2'd0;
      drive_r   <= 1'b0;
      count_r   <= '0;
      kind_r    <= PAT_ALARM;
      on_r      <= '0;
      off_r     <= '0;
    end else if (step) begin
      enabled_r <= enabled_nxt;
      pwm_on_r  <= pwm_on_nxt;
      phase_r   <= phase_nxt;
      drive_r   <= drive_nxt;
      count_r   <= count_nxt;
      kind_r    <= kind_nxt;
      on_r      <= on_nxt;
      off_r     <= off_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/vibration_burst_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// vibration_burst_sequencer_unit
// Burst-pattern vibration motor sequencer with registered event and result.
// ----------------------------------------------------------------------------
// Each input word is one event (pattern tick, PWM tick, start or stop) and
// produces exactly one result word giving the motor drive, sequence enable,
// PWM enable and remaining burst count after that event. A word is captured
// in the input register, the sequencer state is updated from it, and the
// result lands in the output register; a held word waits in the input
// register while the output is stalled. One word is accepted every cycle
// unless the output is stalled, and the input register can still take one
// word while a result waits.
// Durations are six 16-bit registers written through the cfg_ port, which
// is always ready; write them only while no event is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vibration_burst_sequencer_unit
  import vbs_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  // event words
  input  wire logic            in_valid,
  output      logic            in_stall,
  input  wire in_word_t        in_word,
  // result words
  output      logic            out_valid,
  input  wire logic            out_stall,
  output out_word_t            out_word,
  // duration registers
  input  wire logic            cfg_valid,
  output      logic            cfg_ready,
  input  wire logic [IdxW-1:0] cfg_index,
  input  wire logic [DurW-1:0] cfg_data
);

  cfg_t      cfg;
  in_word_t  in_r;
  logic      in_v_r, in_v_nxt;
  out_word_t out_r;
  logic      out_v_r, out_v_nxt;
  out_word_t result_nxt;
  logic      advance;
  logic      take;

  assign cfg_ready = 1'b1;

  vbs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held event into the result register when that register is
  // empty or being drained this cycle.
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  // Hold off new words only while a held event cannot advance.
  assign in_stall = in_v_r && !advance;
  assign take     = in_valid && !in_stall;

  vbs_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .word       (in_r),
    .cfg        (cfg),
    .result_nxt (result_nxt)
  );

  always_comb begin
    in_v_nxt = take ? 1'b1 : (advance ? 1'b0 : in_v_r);
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (take) begin
      in_r <= in_word;
    end
    if (advance) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_word  = out_r;

  // Motor drive and PWM only ever run inside an enabled sequence.
  `VBS_ASSERT_IMP(a_motor_needs_active, clk, rst_n, out_v_r && out_r.motor_on, out_r.active)
  `VBS_ASSERT_IMP(a_pwm_needs_active, clk, rst_n, out_v_r && out_r.pwm_running, out_r.active)
  // The burst count never exceeds the longest pattern.
  `VBS_ASSERT_IMP(a_count_range, clk, rst_n, out_v_r, out_r.bursts_left <= BURSTS_ALARM)
  // An accepted word is held in the input register next cycle.
  `VBS_ASSERT_NXT(a_take_held, clk, rst_n, take, in_v_r)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vibration burst sequencer. A directed table
// walks the corner events first. Randomized event streams follow under
// several duration settings. Every result word is compared field by field
// with a cycle-free model of the burst, off-time and PWM sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import vbs_pkg::*;

  localparam int unsigned NUM_DIRECTED    = 21;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned WATCHDOG_LIMIT  = 500;
  localparam int unsigned DRAIN_CYCLES    = 4;

  localparam out_word_t IDLE_STATUS = '0;

  // One row of the directed table: the event and, where it can be read off
  // directly, the status it must leave behind.
  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t status;
  } dir_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports
  // --------------------------------------------------------------------------
  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  in_word_t        in_word   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  out_word_t       out_word;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [IdxW-1:0] cfg_index = '0;
  logic [DurW-1:0] cfg_data  = '0;

  always #4 clk = ~clk;

  vibration_burst_sequencer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Sequencer model state, reset values match the block after reset
  // --------------------------------------------------------------------------
  cfg_t            dur_cfg       = '0;
  logic            seq_enabled   = 1'b0;
  logic            seq_pwm_on    = 1'b0;
  logic [1:0]      seq_phase     = '0;
  logic            seq_drive     = 1'b0;
  logic [CountW-1:0] seq_count   = '0;
  pat_t            seq_kind      = PAT_ALARM;
  logic [DurW-1:0] seq_on_left   = '0;
  logic [DurW-1:0] seq_off_left  = '0;

  // Status words predicted for accepted events, oldest first.
  out_word_t pending_status[$];

  // Bench bookkeeping.
  int unsigned mismatches   = 0;
  int unsigned words_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned idle_cycles  = 0;
  int unsigned stall_left   = 0;
  bit          no_idle      = 1'b0;

  // Directed table: reset-state events, a full PWM cycle, each start
  // pattern, the zero-duration reload, exhaustion of the count, the
  // keep-previous start and busy starts. Durations are all zero here.
  dir_row_t dir_rows [NUM_DIRECTED] = '{
    // pattern tick, PWM tick and stop while everything is disabled
    '{'{OP_PAT_TICK, PAT_ALARM,    1'b0}, 1'b1, IDLE_STATUS},
    '{'{OP_PWM_TICK, PAT_KEEP,     1'b1}, 1'b1, IDLE_STATUS},
    '{'{OP_STOP,     PAT_TEST,     1'b0}, 1'b1, IDLE_STATUS},
    // busy display swallows the start
    '{'{OP_START,    PAT_ALARM,    1'b1}, 1'b1, IDLE_STATUS},
    '{'{OP_START,    PAT_ALARM,    1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1, BURSTS_ALARM}},
    // one whole PWM cycle: off, off, on
    '{'{OP_PWM_TICK, PAT_INCOMING, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b1, BURSTS_ALARM}},
    '{'{OP_PWM_TICK, PAT_TEST,     1'b1}, 1'b1, '{1'b0, 1'b1, 1'b1, BURSTS_ALARM}},
    '{'{OP_PWM_TICK, PAT_KEEP,     1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1, BURSTS_ALARM}},
    // both durations zero: reload and count down
    '{'{OP_PAT_TICK, PAT_KEEP,     1'b1}, 1'b0, IDLE_STATUS},
    '{'{OP_START,    PAT_INCOMING, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1, BURSTS_INCOMING}},
    '{'{OP_PWM_TICK, PAT_ALARM,    1'b1}, 1'b0, IDLE_STATUS},
    // test start restores phase and motor drive
    '{'{OP_START,    PAT_TEST,     1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1, BURSTS_TEST}},
    '{'{OP_PAT_TICK, PAT_INCOMING, 1'b0}, 1'b0, IDLE_STATUS},
    '{'{OP_PAT_TICK, PAT_TEST,     1'b1}, 1'b0, IDLE_STATUS},
    // count exhausted: this tick halts the sequence
    '{'{OP_PAT_TICK, PAT_ALARM,    1'b0}, 1'b0, IDLE_STATUS},
    '{'{OP_START,    PAT_KEEP,     1'b0}, 1'b0, IDLE_STATUS},
    '{'{OP_STOP,     PAT_INCOMING, 1'b1}, 1'b0, IDLE_STATUS},
    '{'{OP_START,    PAT_KEEP,     1'b1}, 1'b0, IDLE_STATUS},
    '{'{OP_START,    PAT_KEEP,     1'b0}, 1'b0, IDLE_STATUS},
    '{'{OP_PWM_TICK, PAT_TEST,     1'b0}, 1'b0, IDLE_STATUS},
    '{'{OP_PAT_TICK, PAT_KEEP,     1'b0}, 1'b0, IDLE_STATUS}
  };

  // --------------------------------------------------------------------------
  // Sequencer model
  // --------------------------------------------------------------------------

  // Load the on and off times of the stored pattern kind; kind 3 keeps them.
  function automatic void reload_durations();
    case (seq_kind)
      PAT_ALARM: begin
        seq_on_left  = dur_cfg.alarm_on;
        seq_off_left = dur_cfg.alarm_off;
      end
      PAT_INCOMING: begin
        seq_on_left  = dur_cfg.incoming_on;
        seq_off_left = dur_cfg.incoming_off;
      end
      PAT_TEST: begin
        seq_on_left  = dur_cfg.test_on;
        seq_off_left = dur_cfg.test_off;
      end
      default: ;
    endcase
  endfunction

  // Start the next burst: reload, restart the PWM, drop one from the count.
  function automatic void begin_next_burst();
    reload_durations();
    seq_pwm_on = 1'b1;
    seq_count  = seq_count - 1'b1;
  endfunction

  // Motor off always; sequence and PWM off only if the sequence was running.
  function automatic void halt_sequence();
    seq_drive = 1'b0;
    if (seq_enabled) begin
      seq_pwm_on  = 1'b0;
      seq_enabled = 1'b0;
    end
  endfunction

  // Apply one event and return the status it leaves behind.
  function automatic out_word_t advance_sequencer(input in_word_t w);
    out_word_t s;
    case (w.op)
      OP_PAT_TICK: begin
        if (seq_enabled) begin
          if (seq_count != 0) begin
            if (seq_on_left != 0) begin
              seq_on_left = seq_on_left - 1'b1;
              if (seq_on_left == 0) begin
                seq_pwm_on = 1'b0;
                seq_drive  = 1'b0;
              end
            end else if (seq_off_left != 0) begin
              seq_off_left = seq_off_left - 1'b1;
              if (seq_off_left == 0) begin_next_burst();
            end else begin
              begin_next_burst();
            end
          end else begin
            halt_sequence();
          end
        end
      end
      OP_PWM_TICK: begin
        if (seq_pwm_on) begin
          // phase 2, and the unreachable phase 3, wrap to 0
          seq_phase = (seq_phase >= PHASE_LAST) ? 2'd0 : seq_phase + 2'd1;
          seq_drive = (seq_phase == 2'd0);
        end
      end
      OP_START: begin
        if (!w.display_busy) begin
          case (w.pattern)
            PAT_ALARM: begin
              seq_count = BURSTS_ALARM;
              seq_kind  = PAT_ALARM;
              reload_durations();
            end
            PAT_INCOMING: begin
              seq_count = BURSTS_INCOMING;
              seq_kind  = PAT_INCOMING;
              reload_durations();
            end
            PAT_TEST: begin
              // two bursts, but stored as incoming timing
              seq_count = BURSTS_TEST;
              seq_kind  = PAT_INCOMING;
              reload_durations();
            end
            default: ;
          endcase
          seq_enabled = 1'b1;
          seq_phase   = 2'd0;
          seq_drive   = 1'b1;
          seq_pwm_on  = 1'b1;
        end
      end
      default: halt_sequence();
    endcase
    s.motor_on    = seq_drive;
    s.active      = seq_enabled;
    s.pwm_running = seq_pwm_on;
    s.bursts_left = seq_count;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random event; start_pct sets how often a new sequence is kicked off, so
  // low values let bursts run down to the end of the count.
  function automatic in_word_t random_event(input int unsigned start_pct);
    in_word_t    w;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < start_pct)                      w.op = OP_START;
    else if (r < start_pct + start_pct / 2 + 1) w.op = OP_STOP;
    else if (r < 60)                        w.op = OP_PAT_TICK;
    else                                    w.op = OP_PWM_TICK;
    w.pattern      = pat_t'($urandom_range(0, 3));
    w.display_busy = ($urandom_range(0, 3) == 0);
    return w;
  endfunction

  // Duration for one register in a given setting: all zero, all full scale,
  // all one, then mixes biased to short times so bursts complete.
  function automatic logic [DurW-1:0] pick_duration(input int unsigned phase);
    int unsigned r;
    case (phase)
      0: return '0;
      1: return '1;
      2: return DurW'(1);
      default: begin
        r = $urandom_range(0, 99);
        if (r < 70) return DurW'($urandom_range(0, 8));
        if (r < 85) return DurW'($urandom);
        return (r < 92) ? '0 : '1;
      end
    endcase
  endfunction

  // Present one event word and hold it until the block takes it. Returns at
  // the accepting edge.
  task automatic send_word(input in_word_t w);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    words_sent++;
  endtask

  // Write one register and mirror it into the model at the accepting edge.
  task automatic write_register(input logic [IdxW-1:0] idx, input logic [DurW-1:0] data);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      cfg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      REG_ALARM_ON:     dur_cfg.alarm_on     = data;
      REG_ALARM_OFF:    dur_cfg.alarm_off    = data;
      REG_INCOMING_ON:  dur_cfg.incoming_on  = data;
      REG_INCOMING_OFF: dur_cfg.incoming_off = data;
      REG_TEST_ON:      dur_cfg.test_on      = data;
      REG_TEST_OFF:     dur_cfg.test_off     = data;
      default: ;  // indexes past the last register are dropped
    endcase
    reg_writes++;
  endtask

  // Release the input and wait for every predicted status to come back.
  // Each event yields a status word, so an empty queue means nothing is in
  // flight and the duration registers may be touched.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, compare against the oldest prediction, and
  // the no-progress watchdog. Everything is sampled at the rising edge, so
  // values seen are the ones that were set up for that edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t   want;
    int unsigned gap;
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall == 1'b0) begin
        results_seen++;
        if (pending_status.size() == 0) begin
          $error("result word %p arrived with nothing pending", out_word);
          mismatches++;
        end else begin
          want = pending_status.pop_front();
          check_field("motor_on",    8'(want.motor_on),    8'(out_word.motor_on));
          check_field("active",      8'(want.active),      8'(out_word.active));
          check_field("pwm_running", 8'(want.pwm_running), 8'(out_word.pwm_running));
          check_field("bursts_left", 8'(want.bursts_left), 8'(out_word.bursts_left));
        end
      end

      // Reset the watchdog on any handshake, on any of the three channels.
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
          (cfg_valid && cfg_ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("no handshake for %0d cycles, %0d results still pending",
               idle_cycles, pending_status.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end

    // Hold stall for a random stretch, then pick the next one.
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      gap = idle_gap();
      out_stall <= (gap != 0);
      stall_left = (gap != 0) ? gap - 1 : 0;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_word_t    w;
    out_word_t   predicted;
    int unsigned work;
    int unsigned start_pct;

    // Hold reset, then release at an edge.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, durations still at their reset value of zero.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_word(dir_rows[i].word);
      predicted = advance_sequencer(dir_rows[i].word);
      pending_status.push_back(dir_rows[i].typed ? dir_rows[i].status : predicted);
    end

    // Random streams, one duration setting per phase.
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      for (int unsigned idx = 0; idx < 8; idx++) begin
        // registers past the last one get junk that must be dropped
        write_register(IdxW'(idx), (idx < 6) ? pick_duration(phase) : DurW'($urandom));
      end
      cfg_valid <= 1'b0;

      // Every third phase runs with no idling on either side; odd phases
      // start rarely so whole burst sequences play out.
      no_idle   = (phase % 3 == 2);
      start_pct = (phase % 2 == 1) ? 3 : 12;
      work      = 0;
      while (work < ITEMS_PER_PHASE) begin
        w = random_event(start_pct);
        send_word(w);
        pending_status.push_back(advance_sequencer(w));
        work++;
      end
    end

    // Drain, then wait so that any stray result can still show.
    no_idle = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d event words (%0d from the directed table), checked %0d status words.",
             words_sent, NUM_DIRECTED, results_seen);
    $display("Applied %0d register writes over %0d duration settings, %0d mismatches.",
             reg_writes, NUM_PHASES, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/vbs_pkg.sv
rtl/vbs_cfg_regs.sv
rtl/vbs_core.sv
rtl/vibration_burst_sequencer_unit.sv
tb/tb_top.sv
